// File: hw/rtl/rtpf_pkg.sv
// ----------------------------------------------------------------------------
// rtpf_pkg
// Shared constants, types and helpers of the ring topology parent finder.
// ----------------------------------------------------------------------------
`default_nettype none

package rtpf_pkg;

  // Largest table size; slave numbers at or above it overflow.
  localparam int MAX_SLAVES = 256;
  // Width of a slave number, wide enough to hold MAX_SLAVES itself.
  localparam int SLV_W      = $clog2(MAX_SLAVES) + 1;
  // Width of a table index and of the parent field.
  localparam int IDX_W      = $clog2(MAX_SLAVES);
  // Signed branch counter: worst case is +3 for every earlier slave.
  localparam int BR_W       = $clog2(MAX_SLAVES) + 3;
  localparam int PC_W       = 3;
  localparam int MASK_W     = 4;

  // Bit positions of the link and feature flags.
  localparam int LINK_PORT0_BIT = 9;
  localparam int LINK_PORT1_BIT = 11;
  localparam int LINK_PORT2_BIT = 13;
  localparam int LINK_PORT3_BIT = 15;
  localparam int FEAT_CLOCK_BIT = 2;

  // Port counts that move the branch counter.
  localparam logic [PC_W-1:0] PC_ONE   = 3'd1;
  localparam logic [PC_W-1:0] PC_THREE = 3'd3;
  localparam logic [PC_W-1:0] PC_FOUR  = 3'd4;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;    // latch a new request and write its port count
    logic step;      // evaluate one earlier slave of the backward walk
    logic load_out;  // move the finished result into the output register
  } rtpf_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic walk_needed;  // accepted request has a parent walk to do
    logic walk_done;    // current walk step found the parent
    logic out_free;     // output register can take a result this cycle
  } rtpf_sts_t;

  // Change of the branch counter caused by one slave's port count.
  function automatic logic signed [BR_W-1:0] branch_delta(input logic [PC_W-1:0] pc);
    logic signed [BR_W-1:0] d;
    d = '0;
    if (pc == PC_ONE) begin
      d = -BR_W'(signed'(1));
    end else if (pc == PC_THREE) begin
      d = BR_W'(signed'(2));
    end else if (pc == PC_FOUR) begin
      d = BR_W'(signed'(3));
    end
    return d;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/rtpf_ctrl.sv
// ----------------------------------------------------------------------------
// rtpf_ctrl
// Controller of the parent finder: accept, backward walk, result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module rtpf_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_tvalid,
  output logic                    in_tready,
  output rtpf_pkg::rtpf_cmd_t     cmd,
  input  wire rtpf_pkg::rtpf_sts_t sts
);
  import rtpf_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_WALK = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt    = state_r;
    in_tready    = 1'b0;
    cmd          = '0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready  = 1'b1;
        cmd.accept = in_tvalid;
        if (in_tvalid) begin
          state_nxt = sts.walk_needed ? ST_WALK : ST_DONE;
        end
      end
      ST_WALK: begin
        cmd.step = 1'b1;
        if (sts.walk_done) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

`ifndef SYNTHESIS
  // The result never overwrites one that is still waiting downstream.
  a_load_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> sts.out_free)
    else $error("result loaded into a busy output register");

  // A finished walk always hands over to the result stage.
  a_walk_to_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WALK && sts.walk_done) |=> state_r == ST_DONE)
    else $error("walk finished without moving to result stage");

  // Only one request is in work at a time.
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WALK || state_r == ST_DONE) |-> !cmd.accept)
    else $error("request accepted while busy");
`endif

endmodule

`default_nettype wire

// File: hw/rtl/rtpf_dp.sv
// ----------------------------------------------------------------------------
// rtpf_dp
// Datapath: slave numbering, link decode, port count table, walk, output.
// ----------------------------------------------------------------------------
`default_nettype none

module rtpf_dp (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            first_slave,
  input  wire logic [15:0]                     link_status,
  input  wire logic [15:0]                     feature_word,
  input  wire rtpf_pkg::rtpf_cmd_t             cmd,
  output rtpf_pkg::rtpf_sts_t                  sts,
  input  wire logic                            out_ready,
  output logic                                 out_valid,
  output logic [rtpf_pkg::SLV_W-1:0]           out_slave_number,
  output logic [rtpf_pkg::IDX_W-1:0]           out_parent_slave,
  output logic [rtpf_pkg::PC_W-1:0]            out_port_count,
  output logic [rtpf_pkg::MASK_W-1:0]          out_active_ports,
  output logic                                 out_clock_capable,
  output logic                                 out_overflow
);
  import rtpf_pkg::*;

  // Port count table, undefined until written.
  logic [PC_W-1:0] pc_mem [MAX_SLAVES];
  logic [PC_W-1:0] rd_data_r;
  logic [IDX_W-1:0] rd_addr;

  logic [SLV_W-1:0]  sc_r, sc_nxt;
  logic              ovf_in;
  logic [MASK_W-1:0] mask_in;
  logic [PC_W-1:0]   cnt_in;
  logic [IDX_W-1:0]  first_look;

  // Working copy of the request in flight.
  logic [SLV_W-1:0]       sn_r;
  logic [PC_W-1:0]        cnt_r;
  logic [MASK_W-1:0]      mask_r;
  logic                   clk_cap_r;
  logic                   ovf_r;
  logic [IDX_W-1:0]       parent_r;
  logic [IDX_W-1:0]       look_r;
  logic signed [BR_W-1:0] branch_r, branch_new;

  // Output register.
  logic              out_valid_r;
  logic [SLV_W-1:0]  o_sn_r;
  logic [IDX_W-1:0]  o_parent_r;
  logic [PC_W-1:0]   o_cnt_r;
  logic [MASK_W-1:0] o_mask_r;
  logic              o_clk_r;
  logic              o_ovf_r;

  always_comb begin
    if (first_slave) begin
      sc_nxt = SLV_W'(1);
    end else if (sc_r < SLV_W'(MAX_SLAVES)) begin
      sc_nxt = sc_r + SLV_W'(1);
    end else begin
      sc_nxt = sc_r;
    end
  end

  assign ovf_in  = (sc_nxt >= SLV_W'(MAX_SLAVES));
  assign mask_in = {link_status[LINK_PORT3_BIT], link_status[LINK_PORT2_BIT],
                    link_status[LINK_PORT1_BIT], link_status[LINK_PORT0_BIT]};
  assign cnt_in  = PC_W'(mask_in[0]) + PC_W'(mask_in[1])
                 + PC_W'(mask_in[2]) + PC_W'(mask_in[3]);
  assign first_look = IDX_W'(sc_nxt - SLV_W'(1));

  // Prefetch: the read issued now returns the next slave to evaluate.
  assign rd_addr = cmd.accept ? first_look : (look_r - IDX_W'(1));

  always_ff @(posedge clk) begin
    if (cmd.accept && !ovf_in) begin
      pc_mem[sc_nxt[IDX_W-1:0]] <= cnt_in;
    end
    rd_data_r <= pc_mem[rd_addr];
  end

  assign branch_new = branch_r + branch_delta(rd_data_r);

  always_comb begin
    sts.walk_needed = !ovf_in && (sc_nxt > SLV_W'(1));
    sts.walk_done   = ((branch_new > BR_W'(signed'(0))) && (rd_data_r > PC_W'(1)))
                    || (look_r <= IDX_W'(1));
    sts.out_free    = !out_valid_r || out_ready;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sc_r <= '0;
    end else if (cmd.accept) begin
      sc_r <= sc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      sn_r      <= sc_nxt;
      cnt_r     <= cnt_in;
      mask_r    <= mask_in;
      clk_cap_r <= feature_word[FEAT_CLOCK_BIT];
      ovf_r     <= ovf_in;
      parent_r  <= '0;
      look_r    <= first_look;
      branch_r  <= '0;
    end else if (cmd.step) begin
      if (sts.walk_done) begin
        parent_r <= look_r;
      end else begin
        look_r   <= look_r - IDX_W'(1);
        branch_r <= branch_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      o_sn_r     <= sn_r;
      o_parent_r <= parent_r;
      o_cnt_r    <= cnt_r;
      o_mask_r   <= mask_r;
      o_clk_r    <= clk_cap_r;
      o_ovf_r    <= ovf_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_slave_number  = o_sn_r;
  assign out_parent_slave  = o_parent_r;
  assign out_port_count    = o_cnt_r;
  assign out_active_ports  = o_mask_r;
  assign out_clock_capable = o_clk_r;
  assign out_overflow      = o_ovf_r;

`ifndef SYNTHESIS
  // The walk never evaluates below slave 1.
  a_walk_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |-> look_r != '0)
    else $error("walk stepped past slave 1");

  // An overflowing slave reports the master as parent.
  a_ovf_parent: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && o_ovf_r) |-> o_parent_r == '0)
    else $error("overflow result with nonzero parent");

  // A parent always lies before the slave itself.
  a_parent_before: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (SLV_W'(o_parent_r) < o_sn_r))
    else $error("parent not ahead of slave on the bus");
`endif

endmodule

`default_nettype wire

// File: hw/rtl/ring_topology_parent_finder_unit.sv
// ----------------------------------------------------------------------------
// ring_topology_parent_finder_unit
// Numbers bus slaves, decodes their links and finds each one's parent.
// ----------------------------------------------------------------------------
`default_nettype none

// Each request describes one slave, in bus order, and gives one response.
// Slave 1, an overflowing slave and any slave that needs no walk pass to
// the result stage without a walk. Otherwise the block walks back over the
// stored port counts of earlier slaves, one slave per cycle through a
// single read port of the port count table, visiting at most the slave
// number minus one earlier slaves. One request is in work at a time; the
// input is ready again as soon as the response sits in the output
// register, even if the downstream side has not taken it yet. Numbering
// restarts at 1 whenever in_tuser is set, and otherwise counts up from the
// last slave, saturating at the table size, where overflow is flagged, the
// parent reads 0 and nothing is stored. The table needs no clearing after
// reset: a walk only visits slaves of the current numbering run.
module ring_topology_parent_finder_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // [15:0] link_status, [31:16] feature_word
  input  wire logic [0:0]  in_tuser,   // [0] first_slave
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // [8:0] slave_number, [16:9] parent_slave,
                                       // [19:17] port_count, [23:20] active_ports,
                                       // [24] clock_capable, [31:25] zero
  output logic [0:0]       out_tuser   // [0] overflow
);
  import rtpf_pkg::*;

  rtpf_cmd_t cmd;
  rtpf_sts_t sts;

  logic [SLV_W-1:0]  slave_number;
  logic [IDX_W-1:0]  parent_slave;
  logic [PC_W-1:0]   port_count;
  logic [MASK_W-1:0] active_ports;
  logic              clock_capable;
  logic              overflow;

  rtpf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .cmd       (cmd),
    .sts       (sts)
  );

  rtpf_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .first_slave       (in_tuser[0]),
    .link_status       (in_tdata[15:0]),
    .feature_word      (in_tdata[31:16]),
    .cmd               (cmd),
    .sts               (sts),
    .out_ready         (out_tready),
    .out_valid         (out_tvalid),
    .out_slave_number  (slave_number),
    .out_parent_slave  (parent_slave),
    .out_port_count    (port_count),
    .out_active_ports  (active_ports),
    .out_clock_capable (clock_capable),
    .out_overflow      (overflow)
  );

  // Pack the response fields from the lowest bit up, zero filled to 32 bits.
  assign out_tdata = {7'd0, clock_capable, active_ports, port_count,
                      parent_slave, slave_number};
  assign out_tuser = overflow;

endmodule

`default_nettype wire
